FILE: hw/rtl/psts_pkg.sv
// ----------------------------------------------------------------------------
// Priority schedule timing package
// Field widths, transaction payload types and sequencer states shared by the
// priority schedule timing unit and its interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psts_pkg;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int PID_W   = 4;
    localparam int TIME_W  = 20;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  priority_level;
        logic               last_item;
    } psts_in_t;

    typedef struct packed {
        logic [PID_W-1:0]   process_id;
        logic [PRIO_W-1:0]  prio_out;
        logic [BURST_W-1:0] burst_out;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [TIME_W-1:0]  avg_wait;
        logic [TIME_W-1:0]  avg_turnaround;
        logic               last_result;
    } psts_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD_I,
        ST_SORT_LD_I,
        ST_SORT_CMP,
        ST_SORT_WR_I,
        ST_TOT_RD,
        ST_TOT_ACC,
        ST_DIV_W,
        ST_DIV_W_RUN,
        ST_DIV_T,
        ST_DIV_T_RUN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } psts_state_t;

endpackage

FILE: hw/rtl/psts_if.sv
// ----------------------------------------------------------------------------
// Priority schedule timing channel interfaces
// Valid/ready channels for process transactions in and schedule transactions
// out; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psts_in_if
    import psts_pkg::*;
();
    logic     valid;
    logic     ready;
    psts_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface psts_out_if
    import psts_pkg::*;
();
    logic      valid;
    logic      ready;
    psts_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/priority_schedule_timing_unit.sv
// ----------------------------------------------------------------------------
// Priority schedule timing unit
// Loads a set of processes, one per cycle, then sorts them in a RAM by
// priority, sums waits and turnarounds, divides both totals by the count
// and reports each. The single RAM read port and the shared divider make
// the sort, the totals, the two divisions and the reports run in turn.
// Reset is asynchronous and active low; it clears the sequencer and counts,
// while the process RAM holds no defined contents until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_schedule_timing_unit
    import psts_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    psts_in_if.sink    entry,
    psts_out_if.source report
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int ACC_W = BURST_W + $clog2(MAX_PROCESSES);
    localparam int TOT_W = ACC_W + $clog2(MAX_PROCESSES);
    localparam int ENT_W = BURST_W + PRIO_W + IDX_W;

    psts_state_t state_reg, state_next;

    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [ENT_W-1:0] cur_reg, cur_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [TOT_W-1:0] wait_tot_reg, wait_tot_next;
    logic [TOT_W-1:0] turn_tot_reg, turn_tot_next;
    logic [TIME_W-1:0] avg_w_reg, avg_w_next;
    logic [TIME_W-1:0] avg_t_reg, avg_t_next;
    logic             out_valid_reg, out_valid_next;
    psts_out_t        out_reg, out_next;

    logic             in_fire;
    logic             out_fire;
    logic             closing;
    logic [IDX_W-1:0] last_idx;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic [BURST_W-1:0] rd_burst;
    logic [PRIO_W-1:0]  rd_prio;
    logic [IDX_W-1:0]   rd_id;
    logic [PRIO_W-1:0]  cur_prio;

    logic             div_start;
    logic [TOT_W-1:0] div_dividend;
    logic             div_done;
    logic [TOT_W-1:0] div_quotient;

    assign in_fire  = entry.valid && entry.ready;
    assign out_fire = report.valid && report.ready;
    assign closing  = entry.payload.last_item ||
                      (n_reg == CNT_W'(MAX_PROCESSES - 1));
    assign last_idx = IDX_W'(n_reg - 1'b1);

    assign rd_burst = ram_rdata[ENT_W-1 -: BURST_W];
    assign rd_prio  = ram_rdata[IDX_W +: PRIO_W];
    assign rd_id    = ram_rdata[IDX_W-1:0];
    assign cur_prio = cur_reg[IDX_W +: PRIO_W];

    psts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PROCESSES),
        .ADDR_W(IDX_W)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    psts_div #(
        .DW(TOT_W),
        .VW(CNT_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (n_reg),
        .done    (div_done),
        .quotient(div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && closing)
                begin
                    state_next = (n_reg == '0) ? ST_TOT_RD : ST_SORT_RD_I;
                end
            end
            ST_SORT_RD_I: state_next = ST_SORT_LD_I;
            ST_SORT_LD_I: state_next = ST_SORT_CMP;
            ST_SORT_CMP:
            begin
                if (j_reg == last_idx)
                begin
                    state_next = ST_SORT_WR_I;
                end
            end
            ST_SORT_WR_I:
            begin
                if (IDX_W'(i_reg + 1'b1) == last_idx)
                begin
                    state_next = ST_TOT_RD;
                end
                else
                begin
                    state_next = ST_SORT_RD_I;
                end
            end
            ST_TOT_RD: state_next = ST_TOT_ACC;
            ST_TOT_ACC:
            begin
                if (k_reg == last_idx)
                begin
                    state_next = ST_DIV_W;
                end
            end
            ST_DIV_W: state_next = ST_DIV_W_RUN;
            ST_DIV_W_RUN:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_T;
                end
            end
            ST_DIV_T: state_next = ST_DIV_T_RUN;
            ST_DIV_T_RUN:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD:
            begin
                if (out_fire)
                begin
                    state_next = out_reg.last_result ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        wait_tot_next  = wait_tot_reg;
        turn_tot_next  = turn_tot_reg;
        avg_w_next     = avg_w_reg;
        avg_t_next     = avg_t_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = n_reg[IDX_W-1:0];
        ram_wdata      = {entry.payload.burst_time, entry.payload.priority_level,
                          n_reg[IDX_W-1:0]};
        ram_raddr      = k_reg;
        div_start      = 1'b0;
        div_dividend   = wait_tot_reg;
        entry.ready    = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                entry.ready = 1'b1;
                if (in_fire)
                begin
                    ram_we = 1'b1;
                    n_next = n_reg + 1'b1;
                    i_next = '0;
                end
            end
            ST_SORT_RD_I:
            begin
                ram_raddr = i_reg;
            end
            ST_SORT_LD_I:
            begin
                cur_next  = ram_rdata;
                j_next    = IDX_W'(i_reg + 1'b1);
                ram_raddr = IDX_W'(i_reg + 1'b1);
            end
            ST_SORT_CMP:
            begin
                ram_raddr = IDX_W'(j_reg + 1'b1);
                j_next    = IDX_W'(j_reg + 1'b1);
                if (cur_prio > rd_prio)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
            end
            ST_SORT_WR_I:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = cur_reg;
                i_next    = IDX_W'(i_reg + 1'b1);
            end
            ST_TOT_RD:
            begin
                ram_raddr     = '0;
                k_next        = '0;
                acc_next      = '0;
                wait_tot_next = '0;
                turn_tot_next = '0;
            end
            ST_TOT_ACC:
            begin
                ram_raddr     = IDX_W'(k_reg + 1'b1);
                k_next        = IDX_W'(k_reg + 1'b1);
                acc_next      = acc_reg + ACC_W'(rd_burst);
                wait_tot_next = wait_tot_reg + TOT_W'(acc_reg);
                turn_tot_next = turn_tot_reg + TOT_W'(acc_reg + ACC_W'(rd_burst));
            end
            ST_DIV_W:
            begin
                div_start    = 1'b1;
                div_dividend = wait_tot_reg;
            end
            ST_DIV_W_RUN:
            begin
                if (div_done)
                begin
                    avg_w_next = TIME_W'(div_quotient);
                end
            end
            ST_DIV_T:
            begin
                div_start    = 1'b1;
                div_dividend = turn_tot_reg;
            end
            ST_DIV_T_RUN:
            begin
                div_dividend = turn_tot_reg;
                if (div_done)
                begin
                    avg_t_next = TIME_W'(div_quotient);
                    acc_next   = '0;
                    k_next     = '0;
                end
            end
            ST_EMIT_RD:
            begin
                ram_raddr = k_reg;
            end
            ST_EMIT_LD:
            begin
                out_next.process_id      = PID_W'(rd_id);
                out_next.prio_out        = rd_prio;
                out_next.burst_out       = rd_burst;
                out_next.wait_time       = TIME_W'(acc_reg);
                out_next.turnaround_time = TIME_W'(acc_reg + ACC_W'(rd_burst));
                out_next.avg_wait        = avg_w_reg;
                out_next.avg_turnaround  = avg_t_reg;
                out_next.last_result     = (k_reg == last_idx);
                out_valid_next           = 1'b1;
                acc_next                 = acc_reg + ACC_W'(rd_burst);
            end
            ST_EMIT_HOLD:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    k_next         = IDX_W'(k_reg + 1'b1);
                    if (out_reg.last_result)
                    begin
                        n_next        = '0;
                        wait_tot_next = '0;
                        turn_tot_next = '0;
                    end
                end
            end
            default:
            begin
                entry.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            wait_tot_reg  <= '0;
            turn_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            wait_tot_reg  <= wait_tot_next;
            turn_tot_reg  <= turn_tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        acc_reg   <= acc_next;
        avg_w_reg <= avg_w_next;
        avg_t_reg <= avg_t_next;
        out_reg   <= out_next;
    end

    assign report.valid   = out_valid_reg;
    assign report.payload = out_reg;

endmodule

FILE: hw/rtl/psts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/psts_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division producing one quotient bit per cycle; done pulses for
// one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psts_div #(
    parameter int DW = 24,
    parameter int VW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
